// ===== design/skrit_pkg.sv =====
// ============================================================================
// skrit_pkg: shared types and constants for the short key interning table
// Widths, status codes and the queue entry that links front and back end.
// ============================================================================
package skrit_pkg;

  localparam int EntriesPerBucket = 16;
  localparam int BucketCount      = 256;
  localparam int SlotW            = $clog2(EntriesPerBucket);
  localparam int FillW            = $clog2(EntriesPerBucket + 1);
  localparam int BucketW          = 8;
  localparam int AddrW            = BucketW + SlotW;
  localparam int KeyW             = 17;
  localparam int CountW           = 32;

  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_INCREMENTED = 3'd1;
  localparam logic [2:0] ST_DECREMENTED = 3'd2;
  localparam logic [2:0] ST_REMOVED     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [2:0] ST_FULL        = 3'd5;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_DEL = 1'b1;

  // classified request handed from front end to back end
  typedef struct packed {
    logic                op;
    logic [BucketW-1:0]  bucket;
    logic [KeyW-1:0]     key;
  } req_t;

endpackage

// ===== design/short_key_refcount_intern_table_core.sv =====
// ============================================================================
// short_key_refcount_intern_table_core: reference counted short key table
// Interns keys of two or three bytes in 256 sorted buckets with 32-bit
// reference counts; one result beat per input beat.
// ============================================================================
// channel | dir | ports                      | payload
// in      | in  | in_tvalid/tready/tdata     | op, key_length, three key bytes
// out     | out | out_tvalid/tready/tdata    | status, ref_count, sat, fill
//
// Each item runs a binary search over its bucket, p probes (0 to 5); an
// insert or remove then moves the entries behind the slot one at a time,
// since the entry memory has one read and one write port.
// After reset a clearing pass zeroes all 256 entries of the occupancy memory;
// no item is processed meanwhile (input beats still queue, two deep).
// Output stalls hold the result register and the engine waits on it.
// ============================================================================
module short_key_refcount_intern_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[0], key_length[2:1], first_char[10:3], second_char[18:11],
  // third_char[26:19], zero fill to 32 bits
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], ref_count[34:3], count_saturated[35], bucket_fill[40:36]
  output logic [47:0] out_tdata
);

  logic            q_valid, q_pop;
  skrit_pkg::req_t q_head;
  logic            unused_hi;

  assign unused_hi = ^in_tdata[31:27];

  skrit_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata[26:0]),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  skrit_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

`ifndef SYNTH
  // reported fill never exceeds bucket depth
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[40:36] <= 5'd16))
    else $error("bucket fill beyond depth");
  // saturation only flagged on an increment
  a_sat_incr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[35]) |-> (out_tdata[2:0] == skrit_pkg::ST_INCREMENTED))
    else $error("saturation on wrong status");
  // removed and not-found report zero count
  a_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] == skrit_pkg::ST_REMOVED ||
     out_tdata[2:0] == skrit_pkg::ST_NOT_FOUND)) |-> (out_tdata[34:3] == 32'd0))
    else $error("nonzero count on removal");
`endif

endmodule

// ===== design/skrit_front.sv =====
// ============================================================================
// skrit_front: input acceptance and key classification
// Builds the 17-bit tail key from the input beat and pushes it into a
// two-entry queue that the back end drains.
// ============================================================================
module skrit_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [26:0]          in_tdata,
  output logic                 q_valid,
  input  logic                 q_pop,
  output skrit_pkg::req_t      q_head
);

  skrit_pkg::req_t  mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  skrit_pkg::req_t  req;
  logic             len3;
  logic             push;

  // tdata: operation[0], key_length[2:1], first[10:3], second[18:11], third[26:19]
  always_comb begin
    len3       = (in_tdata[2:1] == 2'd3);
    req.op     = in_tdata[0];
    req.bucket = in_tdata[10:3];
    req.key    = {len3, in_tdata[18:11], len3 ? in_tdata[26:19] : 8'd0};
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== design/skrit_back.sv =====
// ============================================================================
// skrit_back: bucket search and update engine
// Binary search over the bucket memory, then in-place count update or an entry
// by entry read-write shift for insert and remove. Result in an out register.
// ============================================================================
module skrit_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  skrit_pkg::req_t      q_head,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FILL, S_SRCH, S_CMP, S_DECIDE, S_SHRD, S_SHWR, S_DONE
  } state_t;

  localparam int EPB = skrit_pkg::EntriesPerBucket;
  localparam int SW  = skrit_pkg::SlotW;
  localparam int FW  = skrit_pkg::FillW;

  // memories
  logic [skrit_pkg::KeyW-1:0]   key_mem   [skrit_pkg::BucketCount*EPB];
  logic [skrit_pkg::CountW-1:0] cnt_mem   [skrit_pkg::BucketCount*EPB];
  logic [FW-1:0]                fill_mem  [skrit_pkg::BucketCount];

  state_t                        st_r;
  skrit_pkg::req_t               req_r;
  logic [FW-1:0]                 fill_r, lo_r, hi_r, mid_r, pos_r, sh_r;
  logic                          found_r;
  logic [skrit_pkg::KeyW-1:0]    rk_r;
  logic [skrit_pkg::CountW-1:0]  rc_r;
  logic [skrit_pkg::BucketW-1:0] clr_r;
  logic [skrit_pkg::AddrW-1:0]   rd_addr;
  logic                          rd_en;
  logic [skrit_pkg::AddrW-1:0]   wr_addr_r;
  logic [skrit_pkg::KeyW-1:0]    wr_key_r;
  logic [skrit_pkg::CountW-1:0]  wr_cnt_r;
  logic                          wr_en_r;
  logic [FW-1:0]                 fw_val;
  logic                          fw_en;
  logic [skrit_pkg::BucketW-1:0] fw_addr;
  logic [FW-1:0]                 fill_rd_r;
  logic [2:0]                    o_status_r;
  logic [skrit_pkg::CountW-1:0]  o_count_r;
  logic                          o_sat_r;
  logic [FW-1:0]                 o_fill_r;
  logic                          o_valid_r;

  function automatic logic [skrit_pkg::AddrW-1:0] addr_of(
    input logic [skrit_pkg::BucketW-1:0] b, input logic [FW-1:0] s);
    addr_of = {b, s[SW-1:0]};
  endfunction

  // entry read address per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_of(req_r.bucket, mid_r);
    if (st_r == S_SRCH) rd_en = 1'b1;
    if (st_r == S_SHRD) begin
      rd_en = 1'b1;
      // insert copies the entry below the gap, remove the entry above it
      if (req_r.op == skrit_pkg::OP_ADD) rd_addr = addr_of(req_r.bucket, sh_r - 1'b1);
      else                               rd_addr = addr_of(req_r.bucket, sh_r);
    end
  end

  // entry memories: one write, one read port
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      key_mem[wr_addr_r] <= wr_key_r;
      cnt_mem[wr_addr_r] <= wr_cnt_r;
    end
    if (rd_en) begin
      rk_r <= key_mem[rd_addr];
      rc_r <= cnt_mem[rd_addr];
    end
  end

  // occupancy memory
  always_ff @(posedge clk) begin
    if (fw_en) fill_mem[fw_addr] <= fw_val;
    fill_rd_r <= fill_mem[q_head.bucket];
  end

  always_comb begin
    fw_en   = (st_r == S_CLEAR) || (st_r == S_DONE);
    fw_addr = (st_r == S_CLEAR) ? clr_r : req_r.bucket;
    fw_val  = (st_r == S_CLEAR) ? '0 : o_fill_r;
  end

  assign q_pop      = (st_r == S_IDLE) && q_valid && !o_valid_r;
  assign out_tvalid = o_valid_r;
  // tdata: status[2:0], ref_count[34:3], count_saturated[35], bucket_fill[40:36]
  assign out_tdata  = {7'd0, o_fill_r, o_sat_r, o_count_r, o_status_r};

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLEAR;
      clr_r     <= '0;
      o_valid_r <= 1'b0;
      wr_en_r   <= 1'b0;
    end else begin
      wr_en_r <= 1'b0;
      if (o_valid_r && out_tready) o_valid_r <= 1'b0;
      unique case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            req_r <= q_head;
            st_r  <= S_FILL;
          end
        end
        S_FILL: begin
          fill_r  <= fill_rd_r;
          lo_r    <= '0;
          hi_r    <= fill_rd_r;
          found_r <= 1'b0;
          mid_r   <= (fill_rd_r - 1'b1) >> 1;
          st_r    <= (fill_rd_r == '0) ? S_DECIDE : S_SRCH;
        end
        S_SRCH: st_r <= S_CMP;
        S_CMP: begin
          if (rk_r == req_r.key) begin
            found_r <= 1'b1;
            pos_r   <= mid_r;
            st_r    <= S_DECIDE;
          end else if (rk_r > req_r.key) begin
            hi_r <= mid_r;
            if (lo_r == mid_r) begin
              pos_r <= lo_r;
              st_r  <= S_DECIDE;
            end else begin
              mid_r <= (lo_r + mid_r - 1'b1) >> 1;
              st_r  <= S_SRCH;
            end
          end else begin
            lo_r <= mid_r + 1'b1;
            if (mid_r + 1'b1 == hi_r) begin
              pos_r <= hi_r;
              st_r  <= S_DECIDE;
            end else begin
              mid_r <= (mid_r + hi_r) >> 1;
              st_r  <= S_SRCH;
            end
          end
        end
        S_DECIDE: begin
          o_sat_r   <= 1'b0;
          o_count_r <= '0;
          o_fill_r  <= fill_r;
          if (!found_r && (st_r == S_DECIDE) && (fill_r == '0)) pos_r <= '0;
          st_r <= S_DONE;
          if (req_r.op == skrit_pkg::OP_ADD) begin
            if (found_r) begin
              o_status_r <= skrit_pkg::ST_INCREMENTED;
              if (rc_r == '1) begin
                o_sat_r   <= 1'b1;
                o_count_r <= rc_r;
              end else begin
                o_count_r <= rc_r + 1'b1;
                wr_en_r   <= 1'b1;
                wr_addr_r <= addr_of(req_r.bucket, pos_r);
                wr_key_r  <= rk_r;
                wr_cnt_r  <= rc_r + 1'b1;
              end
            end else if (fill_r == FW'(EPB)) begin
              o_status_r <= skrit_pkg::ST_FULL;
            end else begin
              o_status_r <= skrit_pkg::ST_INSERTED;
              o_count_r  <= 32'd1;
              o_fill_r   <= fill_r + 1'b1;
              sh_r       <= fill_r;
              st_r       <= S_SHRD;
            end
          end else begin
            if (!found_r) begin
              o_status_r <= skrit_pkg::ST_NOT_FOUND;
            end else if (rc_r > 32'd1) begin
              o_status_r <= skrit_pkg::ST_DECREMENTED;
              o_count_r  <= rc_r - 1'b1;
              wr_en_r    <= 1'b1;
              wr_addr_r  <= addr_of(req_r.bucket, pos_r);
              wr_key_r   <= rk_r;
              wr_cnt_r   <= rc_r - 1'b1;
            end else begin
              o_status_r <= skrit_pkg::ST_REMOVED;
              o_fill_r   <= fill_r - 1'b1;
              sh_r       <= pos_r + 1'b1;
              st_r       <= S_SHRD;
            end
          end
        end
        // shift: insert walks down from the top, remove walks up from pos+1
        S_SHRD: begin
          if (req_r.op == skrit_pkg::OP_ADD) begin
            if (sh_r == pos_r) begin
              wr_en_r   <= 1'b1;
              wr_addr_r <= addr_of(req_r.bucket, pos_r);
              wr_key_r  <= req_r.key;
              wr_cnt_r  <= 32'd1;
              st_r      <= S_DONE;
            end else begin
              sh_r <= sh_r - 1'b1;
              st_r <= S_SHWR;
            end
          end else begin
            if (sh_r == fill_r) st_r <= S_DONE;
            else                st_r <= S_SHWR;
          end
        end
        S_SHWR: begin
          wr_en_r  <= 1'b1;
          wr_key_r <= rk_r;
          wr_cnt_r <= rc_r;
          if (req_r.op == skrit_pkg::OP_ADD) begin
            wr_addr_r <= addr_of(req_r.bucket, sh_r + 1'b1);
          end else begin
            wr_addr_r <= addr_of(req_r.bucket, sh_r - 1'b1);
            sh_r      <= sh_r + 1'b1;
          end
          st_r <= S_SHRD;
        end
        S_DONE: begin
          o_valid_r <= 1'b1;
          st_r      <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
